>>> rtl/mtce_pkg.sv
// Shared constants, types and a helper function for the tour cost evaluator.
package mtce_pkg;

    // Default build parameters
    localparam int MAX_SITES_DEF = 256;
    localparam int DIST_BITS_DEF = 16;

    // Fixed field widths
    localparam int SITE_W   = 8;
    localparam int DIST_W   = 16;
    localparam int ACC_W    = 24;
    localparam int EPS_W    = 32;
    localparam int FRAC_W   = 16;
    localparam int COST_W   = 41;
    localparam int PROD_W   = EPS_W + ACC_W;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 96;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

    // Configuration port
    localparam int PADDR_W = 3;
    localparam logic REG_COST_TYPE = 1'b0;
    localparam logic REG_EPS_FRAC  = 1'b1;

    // Item kinds carried in tuser
    localparam logic OP_TABLE_WR = 1'b0;
    localparam logic OP_SITE     = 1'b1;

    // Cost selection
    localparam logic COST_TOTAL   = 1'b0;
    localparam logic COST_MINIMAX = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic table_wr;   // write distance entry from the input item
        logic capture;    // latch a route site item
        logic rd_leg;     // read leg prev -> site
        logic step_leg;   // apply leg, open segment if needed, read closing leg
        logic add_close;  // add closing leg to segment
        logic tally;      // fold segment into total and max
        logic mult;       // epsilon times total
        logic emit;       // load result register, clear route sums
    } ctl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic item_op;    // kind of the item on the input
        logic closing;    // captured site closes its segment
        logic route_end;  // captured site ends the route
        logic out_free;   // result register can take a new item
    } dp_stat_t;

    // Saturating accumulate
    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [31:0] b);
        logic [32:0] s;
        s = 33'(a) + 33'(b);
        if (s > 33'(ACC_MAX))
            return ACC_MAX;
        return s[ACC_W-1:0];
    endfunction

endpackage

>>> rtl/mtce_ram.sv
// Generic single write port, single read port RAM with registered read.
module mtce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/mtce_ctrl.sv
// Sequencing state machine for table writes and route site evaluation.
module mtce_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  mtce_pkg::dp_stat_t  stat,
    output mtce_pkg::ctl_cmd_t  cmd
);
    import mtce_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEG_RD,
        ST_LEG_ADD,
        ST_CLOSE_ADD,
        ST_TALLY,
        ST_MULT,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (stat.item_op == OP_SITE)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = ST_LEG_RD;
                    end
                    else
                    begin
                        cmd.table_wr = 1'b1;
                    end
                end
            end
            ST_LEG_RD:
            begin
                cmd.rd_leg = 1'b1;
                state_next = ST_LEG_ADD;
            end
            ST_LEG_ADD:
            begin
                cmd.step_leg = 1'b1;
                state_next   = stat.closing ? ST_CLOSE_ADD : ST_IDLE;
            end
            ST_CLOSE_ADD:
            begin
                cmd.add_close = 1'b1;
                state_next    = ST_TALLY;
            end
            ST_TALLY:
            begin
                cmd.tally  = 1'b1;
                state_next = stat.route_end ? ST_MULT : ST_IDLE;
            end
            ST_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // hold until the result register is free
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> rtl/mtce_datapath.sv
// Distance table, route accumulators, cost product and result register.
module mtce_datapath #(
    parameter int MAX_SITES = mtce_pkg::MAX_SITES_DEF,
    parameter int DIST_BITS = mtce_pkg::DIST_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [mtce_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic                             s_tlast,
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mtce_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                             cost_type,
    input  logic [mtce_pkg::EPS_W-1:0]       eps_frac,
    input  mtce_pkg::ctl_cmd_t               cmd,
    output mtce_pkg::dp_stat_t               stat
);
    import mtce_pkg::*;

    localparam int IDX_W   = $clog2(MAX_SITES);
    localparam int ADDR_W  = 2 * IDX_W;
    localparam int DEPTH   = 1 << ADDR_W;

    // Input item fields
    logic [SITE_W-1:0] in_from;
    logic [SITE_W-1:0] in_to;
    logic [DIST_W-1:0] in_dist;
    logic [SITE_W-1:0] in_site;
    logic              in_seg_end;

    assign in_from    = s_tdata[7:0];
    assign in_to      = s_tdata[15:8];
    assign in_dist    = s_tdata[31:16];
    assign in_site    = s_tdata[39:32];
    assign in_seg_end = s_tdata[40];

    // Route state
    logic [SITE_W-1:0] site_reg;
    logic              closing_reg;
    logic              rt_end_reg;
    logic [SITE_W-1:0] first_reg;
    logic [SITE_W-1:0] prev_reg;
    logic              in_seg_reg;
    logic [ACC_W-1:0]  seg_reg;
    logic [ACC_W-1:0]  total_reg;
    logic [ACC_W-1:0]  max_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              rd_ok_reg;

    // Result register
    logic              out_valid_reg;
    logic [ACC_W-1:0]  out_total_reg;
    logic [ACC_W-1:0]  out_max_reg;
    logic [COST_W-1:0] out_cost_reg;
    logic [COST_W-1:0] cost_next;

    // Table access
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 rd_ok;
    logic [DIST_BITS-1:0] rd_data;
    logic [DIST_BITS-1:0] leg_val;
    logic [SITE_W-1:0]    first_eff;
    logic                 site_ok;
    logic                 prev_ok;
    logic                 first_ok;
    logic [ACC_W-1:0]     seg_closed;

    assign site_ok   = 32'(site_reg) < 32'(MAX_SITES);
    assign prev_ok   = 32'(prev_reg) < 32'(MAX_SITES);
    assign first_eff = in_seg_reg ? first_reg : site_reg;
    assign first_ok  = 32'(first_eff) < 32'(MAX_SITES);

    // Table write, out-of-range entries dropped
    assign wr_en   = cmd.table_wr && (32'(in_from) < 32'(MAX_SITES))
                     && (32'(in_to) < 32'(MAX_SITES));
    assign wr_addr = {IDX_W'(in_from), IDX_W'(in_to)};

    // Leg read: prev -> site, then site -> first of segment
    always_comb
    begin
        rd_en   = cmd.rd_leg || cmd.step_leg;
        rd_addr = {IDX_W'(prev_reg), IDX_W'(site_reg)};
        rd_ok   = prev_ok && site_ok;
        if (cmd.step_leg)
        begin
            rd_addr = {IDX_W'(site_reg), IDX_W'(first_eff)};
            rd_ok   = site_ok && first_ok;
        end
    end

    mtce_ram #(
        .WIDTH (DIST_BITS),
        .DEPTH (DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (DIST_BITS'(in_dist)),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // a leg touching an unknown site counts as zero
    assign leg_val    = rd_ok_reg ? rd_data : '0;
    assign seg_closed = seg_reg;

    // Cost from the total, or for minimax from the largest segment plus the registered product
    always_comb
    begin
        if (cost_type == COST_MINIMAX)
            cost_next = (COST_W'(max_reg) << FRAC_W) + COST_W'(prod_reg[PROD_W-1:FRAC_W]);
        else
            cost_next = COST_W'(total_reg) << FRAC_W;
    end

    // Item capture, segment start, product and result register, payload only
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            site_reg    <= in_site;
            closing_reg <= in_seg_end || s_tlast;
            rt_end_reg  <= s_tlast;
        end
        if (cmd.step_leg && !in_seg_reg)
            first_reg <= site_reg;
        if (cmd.mult)
            prod_reg <= PROD_W'(eps_frac) * PROD_W'(total_reg);
        if (cmd.emit)
        begin
            out_total_reg <= total_reg;
            out_max_reg   <= max_reg;
            out_cost_reg  <= cost_next;
        end
    end

    // Route accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= '0;
            in_seg_reg <= 1'b0;
            seg_reg    <= '0;
            total_reg  <= '0;
            max_reg    <= '0;
            rd_ok_reg  <= 1'b0;
        end
        else
        begin
            if (rd_en)
                rd_ok_reg <= rd_ok;
            if (cmd.step_leg)
            begin
                prev_reg <= site_reg;
                if (in_seg_reg)
                    seg_reg <= sat_add(seg_reg, 32'(leg_val));
                else
                begin
                    seg_reg    <= '0;
                    in_seg_reg <= 1'b1;
                end
            end
            if (cmd.add_close)
                seg_reg <= sat_add(seg_reg, 32'(leg_val));
            if (cmd.tally)
            begin
                total_reg  <= sat_add(total_reg, 32'(seg_closed));
                if (seg_closed > max_reg)
                    max_reg <= seg_closed;
                in_seg_reg <= 1'b0;
            end
            if (cmd.emit)
            begin
                total_reg <= '0;
                max_reg   <= '0;
                seg_reg   <= '0;
            end
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_DATA_W - COST_W - 2 * ACC_W)'(0), out_cost_reg,
                       out_max_reg, out_total_reg};

    // Status
    assign stat.item_op   = s_tuser;
    assign stat.closing   = closing_reg;
    assign stat.route_end = rt_end_reg;
    assign stat.out_free  = !out_valid_reg || m_tready;

    // Checks
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || m_tready))
        else $error("result loaded over a pending item");

    a_total_covers_max: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg >= max_reg)
        else $error("largest segment exceeds total");

    a_tally_max: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tally |=> max_reg >= seg_reg)
        else $error("largest segment not updated");

    a_seg_close: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_seg_reg) |-> $past(cmd.tally))
        else $error("segment closed outside tally");

endmodule

>>> rtl/multi_tour_cost_evaluator.sv
// A table write is done on acceptance; a route site goes through leg read and leg add,
// then close add and tally if it closes a segment, then multiply and emit if it ends
// the route; emit is held while the previous result still waits on m_tready.
// A new item waits until the last is done; one table read port serves both leg reads.
// Reset (rst_n, async low) clears route sums, config and control; the distance
// table has no reset and must be loaded before use.
module multi_tour_cost_evaluator #(
    parameter int MAX_SITES = mtce_pkg::MAX_SITES_DEF,
    parameter int DIST_BITS = mtce_pkg::DIST_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input items
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // from_site, to_site, distance, site, segment_end (low bit up)
    input  logic [mtce_pkg::IN_DATA_W-1:0]   s_tdata,
    // route_end
    input  logic                             s_tlast,
    // operation
    input  logic                             s_tuser,
    // result items
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // total_distance, largest_segment, cost (low bit up)
    output logic [mtce_pkg::OUT_DATA_W-1:0]  m_tdata,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mtce_pkg::PADDR_W-1:0]     paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import mtce_pkg::*;

    logic             cost_type_reg;
    logic [EPS_W-1:0] eps_frac_reg;
    logic             reg_wr;
    logic             reg_sel;
    ctl_cmd_t         cmd;
    dp_stat_t         stat;

    // Register file
    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign reg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cost_type_reg <= COST_TOTAL;
            eps_frac_reg  <= '0;
        end
        else if (reg_wr)
        begin
            case (reg_sel)
                REG_COST_TYPE: cost_type_reg <= pwdata[0];
                REG_EPS_FRAC:  eps_frac_reg  <= pwdata;
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_COST_TYPE: prdata = {31'b0, cost_type_reg};
            REG_EPS_FRAC:  prdata = eps_frac_reg;
            default:       prdata = '0;
        endcase
    end

    mtce_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mtce_datapath #(
        .MAX_SITES (MAX_SITES),
        .DIST_BITS (DIST_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cost_type (cost_type_reg),
        .eps_frac  (eps_frac_reg),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
